// File: rtl/core/bwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwm_pkg
// Shared widths, register map and types of the barcode window matcher.
// ----------------------------------------------------------------------------
package bwm_pkg;

  localparam int DEF_WINDOW      = 200;
  localparam int DEF_MAX_READ    = 2048;
  localparam int DEF_MAX_PATTERN = 32;

  localparam int BASE_W     = 3;
  localparam int RLEN_W     = 11;
  localparam int POS_W      = 9;
  localparam int LEN_W      = 6;
  localparam int PAT_W      = 64;
  localparam int PAT_BASES  = PAT_W / 2;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 64;
  localparam int REG_SEL_W  = 2;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(8);

  typedef enum logic [REG_SEL_W-1:0] {
    REG_HEAD_PATTERN = 2'd0,
    REG_HEAD_LENGTH  = 2'd1,
    REG_TAIL_PATTERN = 2'd2,
    REG_TAIL_LENGTH  = 2'd3
  } bwm_reg_t;

  // Barcode prepared for a parallel compare against the base history.
  // expect_bases holds the wanted base for history slot j at bits 2j+1..2j.
  typedef struct packed {
    logic [PAT_W-1:0]     expect_bases;
    logic [PAT_BASES-1:0] slot_mask;
    logic [LEN_W-1:0]     length;
  } bwm_barcode_t;

  typedef struct packed {
    bwm_barcode_t head;
    bwm_barcode_t tail;
  } bwm_cfg_t;

endpackage

// File: rtl/core/bwm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwm_if
// Stream channels of the barcode window matcher: read bases in, results out.
// ----------------------------------------------------------------------------
interface bwm_in_if;
  logic                        valid;
  logic                        ready;
  logic [bwm_pkg::BASE_W-1:0]  base;
  logic [bwm_pkg::RLEN_W-1:0]  read_length;
  logic                        last_base;

  modport source (output valid, output base, output read_length, output last_base,
                  input ready);
  modport sink   (input valid, input base, input read_length, input last_base,
                  output ready);
endinterface

interface bwm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [bwm_pkg::POS_W-1:0]  head_position;
  logic signed [bwm_pkg::POS_W-1:0]  tail_position;
  logic                              keep_read;

  modport source (output valid, output head_position, output tail_position,
                  output keep_read, input ready);
  modport sink   (input valid, input head_position, input tail_position,
                  input keep_read, output ready);
endinterface

// File: rtl/core/bwm_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwm_cfg_regs
// APB register file for both barcodes; prepares aligned compare patterns.
// ----------------------------------------------------------------------------
module bwm_cfg_regs #(
  parameter int MAX_PATTERN = bwm_pkg::DEF_MAX_PATTERN
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bwm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bwm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bwm_pkg::APB_DATA_W-1:0] prdata,
  output bwm_pkg::bwm_cfg_t              cfg
);
  import bwm_pkg::*;

  localparam int SH_W = $clog2(MAX_PATTERN + 1);

  logic [PAT_W-1:0] head_pattern;
  logic [LEN_W-1:0] head_length;
  logic [PAT_W-1:0] tail_pattern;
  logic [LEN_W-1:0] tail_length;

  bwm_reg_t     sel;
  logic         wr_en;
  bwm_barcode_t head_next;
  bwm_barcode_t tail_next;

  assign sel   = bwm_reg_t'(paddr[APB_ADDR_W-1:APB_ADDR_W-REG_SEL_W]);
  assign wr_en = psel && penable && pwrite;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] res;
    res = len;
    if (len == '0) begin
      res = LEN_W'(1);
    end else if (len > LEN_W'(MAX_PATTERN)) begin
      res = LEN_W'(MAX_PATTERN);
    end
    return res;
  endfunction

  function automatic bwm_barcode_t prepare(input logic [PAT_W-1:0] pat,
                                           input logic [LEN_W-1:0] len);
    bwm_barcode_t     res;
    logic [LEN_W-1:0] cl;
    logic [PAT_W-1:0] rev;
    logic [SH_W-1:0]  sh;
    cl  = clamp_len(len);
    rev = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      rev[2*j +: 2] = pat[2*(MAX_PATTERN-1-j) +: 2];
    end
    sh = SH_W'(MAX_PATTERN) - SH_W'(cl);
    res.expect_bases = rev >> {sh, 1'b0};
    for (int j = 0; j < PAT_BASES; j++) begin
      res.slot_mask[j] = (LEN_W'(j) < cl) && (j < MAX_PATTERN);
    end
    res.length = cl;
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      head_pattern <= '0;
      head_length  <= LEN_RESET;
      tail_pattern <= '0;
      tail_length  <= LEN_RESET;
    end else if (wr_en) begin
      case (sel)
        REG_HEAD_PATTERN: head_pattern <= pwdata;
        REG_HEAD_LENGTH:  head_length  <= pwdata[LEN_W-1:0];
        REG_TAIL_PATTERN: tail_pattern <= pwdata;
        REG_TAIL_LENGTH:  tail_length  <= pwdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_HEAD_PATTERN: prdata = head_pattern;
      REG_HEAD_LENGTH:  prdata = APB_DATA_W'(head_length);
      REG_TAIL_PATTERN: prdata = tail_pattern;
      REG_TAIL_LENGTH:  prdata = APB_DATA_W'(tail_length);
      default:          prdata = '0;
    endcase
  end

  assign head_next = prepare(head_pattern, head_length);
  assign tail_next = prepare(tail_pattern, tail_length);

  always_ff @(posedge clk) begin
    cfg.head <= head_next;
    cfg.tail <= tail_next;
  end

endmodule

// File: rtl/core/bwm_window_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwm_window_cmp
// Parallel compare of the newest bases against one prepared barcode.
// ----------------------------------------------------------------------------
module bwm_window_cmp #(
  parameter int MAX_PATTERN = bwm_pkg::DEF_MAX_PATTERN
) (
  input  logic [MAX_PATTERN-1:0][bwm_pkg::BASE_W-1:0] history,
  input  bwm_pkg::bwm_barcode_t                       barcode,
  output logic                                        hit
);
  import bwm_pkg::*;

  logic [MAX_PATTERN-1:0] slot_ok;

  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      slot_ok[j] = !barcode.slot_mask[j] ||
                   (history[j] == {1'b0, barcode.expect_bases[2*j +: 2]});
    end
  end

  assign hit = &slot_ok;

endmodule

// File: rtl/core/barcode_window_matcher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barcode_window_matcher_unit
// Exact-match search of a head and a tail barcode in the windows of a read.
// ----------------------------------------------------------------------------
// Result path: the last base is registered in the input stage, then its result is registered in the result register.
// Throughput: 1 base per cycle; the single compare stage updates the history
// and match flags for each base it holds and stalls only while a result waits downstream.
// Reset: synchronous rst clears registers, base history and match state;
// prepared barcodes are registered from the registers and follow them in the next cycle.
// ----------------------------------------------------------------------------
module barcode_window_matcher_unit #(
  parameter int WINDOW      = bwm_pkg::DEF_WINDOW,
  parameter int MAX_READ    = bwm_pkg::DEF_MAX_READ,
  parameter int MAX_PATTERN = bwm_pkg::DEF_MAX_PATTERN
) (
  input  logic                           clk,
  input  logic                           rst,
  bwm_in_if.sink                         read_bases,
  bwm_out_if.source                      match_result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bwm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bwm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bwm_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import bwm_pkg::*;

  localparam int IW = $clog2(MAX_READ);
  localparam int CW = ((IW > RLEN_W) ? IW : RLEN_W) + 2;

  bwm_cfg_t cfg;

  logic                   s1_valid;
  logic [BASE_W-1:0]      s1_base;
  logic [RLEN_W-1:0]      s1_rlen;
  logic                   s1_last;

  logic [MAX_PATTERN-1:0][BASE_W-1:0] history;
  logic [MAX_PATTERN-1:0][BASE_W-1:0] history_next;
  logic [IW-1:0]          base_index;
  logic                   head_found;
  logic [POS_W-1:0]       head_start;
  logic                   tail_found;
  logic [POS_W-1:0]       tail_start_pos;

  logic                   head_hit;
  logic                   tail_hit;
  logic                   advance;
  logic                   in_fire;

  logic [CW-1:0]          idx_w;
  logic [CW-1:0]          idx_end;
  logic [CW-1:0]          rlen_w;
  logic [CW-1:0]          hl_w;
  logic [CW-1:0]          tl_w;
  logic [CW-1:0]          head_end;
  logic [CW-1:0]          tail_base;
  logic [CW-1:0]          tail_rel;
  logic                   head_take;
  logic                   tail_take;
  logic                   head_found_next;
  logic [POS_W-1:0]       head_start_next;
  logic                   tail_found_next;
  logic [POS_W-1:0]       tail_start_next;

  assign pready = 1'b1;

  bwm_cfg_regs #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // hold a finished last base while the result register is still occupied
  assign advance = s1_valid && !(s1_last && match_result.valid && !match_result.ready);
  assign read_bases.ready = !s1_valid || advance;
  assign in_fire = read_bases.valid && read_bases.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_base <= read_bases.base;
      s1_rlen <= read_bases.read_length;
      s1_last <= read_bases.last_base;
    end
  end

  assign history_next = {history[MAX_PATTERN-2:0], s1_base};

  bwm_window_cmp #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_head_cmp (
    .history (history_next),
    .barcode (cfg.head),
    .hit     (head_hit)
  );

  bwm_window_cmp #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_tail_cmp (
    .history (history_next),
    .barcode (cfg.tail),
    .hit     (tail_hit)
  );

  always_comb begin
    idx_w     = CW'(base_index);
    idx_end   = idx_w + CW'(1);
    rlen_w    = CW'(s1_rlen);
    hl_w      = CW'(cfg.head.length);
    tl_w      = CW'(cfg.tail.length);
    head_end  = (rlen_w < CW'(WINDOW)) ? rlen_w : CW'(WINDOW);
    tail_base = (rlen_w > CW'(WINDOW)) ? (rlen_w - CW'(WINDOW)) : '0;
    tail_rel  = idx_end - tl_w;

    head_take = !head_found && (idx_end >= hl_w) && (idx_w < head_end) && head_hit;
    tail_take = !tail_found && (idx_end >= tl_w) && (idx_w < rlen_w) &&
                (tail_rel >= tail_base) && tail_hit;

    head_found_next = head_found || head_take;
    head_start_next = head_take ? POS_W'(idx_end - hl_w) : head_start;
    tail_found_next = tail_found || tail_take;
    tail_start_next = tail_take ? POS_W'(tail_rel - tail_base) : tail_start_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history        <= '0;
      base_index     <= '0;
      head_found     <= 1'b0;
      head_start     <= '0;
      tail_found     <= 1'b0;
      tail_start_pos <= '0;
    end else if (advance) begin
      if (s1_last) begin
        history        <= '0;
        base_index     <= '0;
        head_found     <= 1'b0;
        head_start     <= '0;
        tail_found     <= 1'b0;
        tail_start_pos <= '0;
      end else begin
        history        <= history_next;
        head_found     <= head_found_next;
        head_start     <= head_start_next;
        tail_found     <= tail_found_next;
        tail_start_pos <= tail_start_next;
        if (base_index != IW'(MAX_READ - 1)) begin
          base_index <= base_index + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_result.valid <= 1'b0;
    end else if (advance && s1_last) begin
      match_result.valid <= 1'b1;
    end else if (match_result.ready) begin
      match_result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last) begin
      match_result.head_position <= head_found_next ? $signed(head_start_next) : '1;
      match_result.tail_position <= tail_found_next ? $signed(tail_start_next) : '1;
      match_result.keep_read     <= head_found_next || tail_found_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_keep_consistent: assert property (@(posedge clk) disable iff (rst)
    match_result.valid |->
      (match_result.keep_read ==
       ((match_result.head_position != '1) || (match_result.tail_position != '1))))
    else $error("keep_read disagrees with reported positions");

  a_read_cleared: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_last) |=> (base_index == '0) && !head_found && !tail_found)
    else $error("read state not cleared after last base");

  a_head_sticky: assert property (@(posedge clk) disable iff (rst)
    (head_found && !(advance && s1_last)) |=> head_found && $stable(head_start))
    else $error("head match lost within a read");

  a_tail_sticky: assert property (@(posedge clk) disable iff (rst)
    (tail_found && !(advance && s1_last)) |=> tail_found && $stable(tail_start_pos))
    else $error("tail match lost within a read");
`endif

endmodule
